// ===== hdl/frgcd_pkg.sv =====
package frgcd_pkg;

    localparam int STEP_W = 4;

    typedef logic [STEP_W-1:0] step_t;

    // Datapath operations, one per control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_SET_G_A,
        OP_SET_G_B,
        OP_SHR_AB,
        OP_SHR_A,
        OP_SHR_B,
        OP_SUB,
        OP_SET_G_GCD,
        OP_DIV_INIT_N,
        OP_DIV_INIT_D,
        OP_DIV_STEP,
        OP_FINISH,
        OP_FINISH_ERR
    } op_t;

    // Conditions that a control word can jump on.
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_BOTH_ZERO,
        COND_A_ZERO,
        COND_B_ZERO,
        COND_AB_EVEN,
        COND_A_EVEN,
        COND_B_EVEN,
        COND_A_NE_B,
        COND_CNT_LAST,
        COND_OUT_STALL
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  inv;
        step_t target;
        logic  last;
    } ucode_t;

    typedef struct packed {
        logic both_zero;
        logic a_zero;
        logic b_zero;
        logic ab_even;
        logic a_even;
        logic b_even;
        logic a_ne_b;
        logic cnt_last;
        logic out_stall;
    } status_t;

    localparam step_t S_CHECK = step_t'(0);
    localparam step_t S_GB    = step_t'(1);
    localparam step_t S_GA    = step_t'(2);
    localparam step_t S_TWOS  = step_t'(3);
    localparam step_t S_AODD  = step_t'(4);
    localparam step_t S_BODD  = step_t'(5);
    localparam step_t S_SUB   = step_t'(6);
    localparam step_t S_GCD   = step_t'(7);
    localparam step_t S_DIVN  = step_t'(8);
    localparam step_t S_DSTN  = step_t'(9);
    localparam step_t S_DIVD  = step_t'(10);
    localparam step_t S_DSTD  = step_t'(11);
    localparam step_t S_FIN   = step_t'(12);
    localparam step_t S_ERR   = step_t'(13);

    // The control program. A jump is taken when the condition, optionally
    // inverted, holds; otherwise the sequencer steps on or ends on a last word.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '{op: OP_NOP, cond: COND_NEVER, inv: 1'b0, target: S_CHECK, last: 1'b1};
        unique case (step)
            S_CHECK: w = '{OP_NOP,        COND_BOTH_ZERO, 1'b0, S_ERR,   1'b0};
            S_GB:    w = '{OP_SET_G_B,    COND_A_ZERO,    1'b0, S_DIVN,  1'b0};
            S_GA:    w = '{OP_SET_G_A,    COND_B_ZERO,    1'b0, S_DIVN,  1'b0};
            S_TWOS:  w = '{OP_SHR_AB,     COND_AB_EVEN,   1'b0, S_TWOS,  1'b0};
            S_AODD:  w = '{OP_SHR_A,      COND_A_EVEN,    1'b0, S_AODD,  1'b0};
            S_BODD:  w = '{OP_SHR_B,      COND_B_EVEN,    1'b0, S_BODD,  1'b0};
            S_SUB:   w = '{OP_SUB,        COND_A_NE_B,    1'b0, S_BODD,  1'b0};
            S_GCD:   w = '{OP_SET_G_GCD,  COND_NEVER,     1'b0, S_CHECK, 1'b0};
            S_DIVN:  w = '{OP_DIV_INIT_N, COND_NEVER,     1'b0, S_CHECK, 1'b0};
            S_DSTN:  w = '{OP_DIV_STEP,   COND_CNT_LAST,  1'b1, S_DSTN,  1'b0};
            S_DIVD:  w = '{OP_DIV_INIT_D, COND_NEVER,     1'b0, S_CHECK, 1'b0};
            S_DSTD:  w = '{OP_DIV_STEP,   COND_CNT_LAST,  1'b1, S_DSTD,  1'b0};
            S_FIN:   w = '{OP_FINISH,     COND_OUT_STALL, 1'b0, S_FIN,   1'b1};
            S_ERR:   w = '{OP_FINISH_ERR, COND_OUT_STALL, 1'b0, S_ERR,   1'b1};
            default: w = '{OP_NOP,        COND_NEVER,     1'b0, S_CHECK, 1'b1};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/frgcd_sequencer.sv =====
module frgcd_sequencer
    import frgcd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    start,
    input  status_t status,
    output op_t     op,
    output logic    busy
);

    step_t  pc_reg;
    logic   busy_reg;
    ucode_t uw;
    logic   cond_hit;
    logic   jump;

    assign uw = ucode_rom(pc_reg);

    always_comb begin
        unique case (uw.cond)
            COND_NEVER:     cond_hit = 1'b0;
            COND_BOTH_ZERO: cond_hit = status.both_zero;
            COND_A_ZERO:    cond_hit = status.a_zero;
            COND_B_ZERO:    cond_hit = status.b_zero;
            COND_AB_EVEN:   cond_hit = status.ab_even;
            COND_A_EVEN:    cond_hit = status.a_even;
            COND_B_EVEN:    cond_hit = status.b_even;
            COND_A_NE_B:    cond_hit = status.a_ne_b;
            COND_CNT_LAST:  cond_hit = status.cnt_last;
            COND_OUT_STALL: cond_hit = status.out_stall;
            default:        cond_hit = 1'b0;
        endcase
    end

    assign jump = cond_hit ^ uw.inv;
    assign op   = busy_reg ? uw.op : OP_NOP;
    assign busy = busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= S_CHECK;
        end else if (start) begin
            busy_reg <= 1'b1;
            pc_reg   <= S_CHECK;
        end else if (busy_reg) begin
            priority if (jump) begin
                pc_reg <= uw.target;
            end else if (uw.last) begin
                busy_reg <= 1'b0;
            end else begin
                pc_reg <= pc_reg + step_t'(1);
            end
        end
    end

endmodule

// ===== hdl/frgcd_datapath.sv =====
module frgcd_datapath
    import frgcd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] num_in,
    input  logic [DATA_WIDTH-1:0] den_in,
    input  op_t                   op,
    input  logic                  out_free,
    output status_t               status,
    output logic [DATA_WIDTH-1:0] gcd,
    output logic [DATA_WIDTH-1:0] num_quot,
    output logic [DATA_WIDTH-1:0] den_quot,
    output logic                  num_neg,
    output logic                  den_neg
);

    localparam int TWOS_W = $clog2(DATA_WIDTH);
    localparam int CNT_W  = $clog2(DATA_WIDTH + 1);
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] a_reg, b_reg, mn_reg, md_reg, g_reg;
    logic [DATA_WIDTH-1:0] q_reg, qn_reg, rem_reg;
    logic [TWOS_W-1:0]     twos_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  num_neg_reg, den_neg_reg;

    logic [DATA_WIDTH-1:0] num_mag, den_mag;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   trial_diff;
    logic                  a_gt_b;

    // Magnitudes as unsigned words: the most negative value maps exactly.
    assign num_mag = num_in[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - num_in) : num_in;
    assign den_mag = den_in[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - den_in) : den_in;

    assign trial      = {rem_reg, q_reg[DATA_WIDTH-1]};
    assign trial_diff = trial - {1'b0, g_reg};
    assign a_gt_b     = a_reg > b_reg;

    always_comb begin
        status.both_zero = (a_reg == '0) && (b_reg == '0);
        status.a_zero    = a_reg == '0;
        status.b_zero    = b_reg == '0;
        status.ab_even   = !a_reg[0] && !b_reg[0];
        status.a_even    = !a_reg[0];
        status.b_even    = !b_reg[0];
        status.a_ne_b    = a_reg != b_reg;
        status.cnt_last  = cnt_reg == CNT_W'(1);
        status.out_stall = !out_free;
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg       <= num_mag;
            b_reg       <= den_mag;
            mn_reg      <= num_mag;
            md_reg      <= den_mag;
            num_neg_reg <= num_in[DATA_WIDTH-1];
            den_neg_reg <= den_in[DATA_WIDTH-1];
            twos_reg    <= '0;
        end else begin
            unique case (op)
                OP_SET_G_A: g_reg <= a_reg;
                OP_SET_G_B: g_reg <= b_reg;
                OP_SHR_AB: begin
                    if (!a_reg[0] && !b_reg[0]) begin
                        a_reg    <= a_reg >> 1;
                        b_reg    <= b_reg >> 1;
                        twos_reg <= twos_reg + TWOS_W'(1);
                    end
                end
                OP_SHR_A: begin
                    if (!a_reg[0]) begin
                        a_reg <= a_reg >> 1;
                    end
                end
                OP_SHR_B: begin
                    if (!b_reg[0]) begin
                        b_reg <= b_reg >> 1;
                    end
                end
                OP_SUB: begin
                    // Keep the smaller odd value in a and the difference in b.
                    if (a_gt_b) begin
                        a_reg <= b_reg;
                        b_reg <= a_reg - b_reg;
                    end else begin
                        b_reg <= b_reg - a_reg;
                    end
                end
                OP_SET_G_GCD: g_reg <= a_reg << twos_reg;
                OP_DIV_INIT_N: begin
                    q_reg   <= mn_reg;
                    rem_reg <= '0;
                    cnt_reg <= CNT_INIT;
                end
                OP_DIV_INIT_D: begin
                    qn_reg  <= q_reg;
                    q_reg   <= md_reg;
                    rem_reg <= '0;
                    cnt_reg <= CNT_INIT;
                end
                OP_DIV_STEP: begin
                    // Restoring division, one quotient bit per step.
                    if (!trial_diff[DATA_WIDTH]) begin
                        rem_reg <= trial_diff[DATA_WIDTH-1:0];
                        q_reg   <= {q_reg[DATA_WIDTH-2:0], 1'b1};
                    end else begin
                        rem_reg <= trial[DATA_WIDTH-1:0];
                        q_reg   <= {q_reg[DATA_WIDTH-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    assign gcd      = g_reg;
    assign num_quot = qn_reg;
    assign den_quot = q_reg;
    assign num_neg  = num_neg_reg;
    assign den_neg  = den_neg_reg;

endmodule

// ===== hdl/fraction_reduce_binary_gcd.sv =====
// Reduces a signed fraction: returns the greatest common divisor of the
// magnitudes of numerator and denominator (Stein's binary method) and both
// parts divided exactly by it, with their signs kept. A zero part makes the
// other part's magnitude the divisor; both zero raise m_undefined_flag with
// all other result fields zero. A divisor of 2^(DATA_WIDTH-1) reads as
// 2^(DATA_WIDTH-1)-1 in m_common_divisor. One transaction is processed at a
// time under a microcoded sequencer. With both parts nonzero it first
// strips the shared factors of two, then halves each operand until it is
// odd and subtracts until they are equal, and shifts the shared twos back
// in to form the divisor. A zero part skips the binary loop; both zero go
// straight to the flag. The two exact divisions then produce one quotient
// bit per cycle. A finished result waits while the previous result has not
// been taken. A finished result is held in an output register, so a new
// transaction is accepted from the cycle after the result is loaded, while
// that result waits.
module fraction_reduce_binary_gcd
    import frgcd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_WIDTH-1:0] s_num_in,
    input  logic [DATA_WIDTH-1:0] s_den_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_WIDTH-2:0] m_common_divisor,
    output logic [DATA_WIDTH-1:0] m_num_out,
    output logic [DATA_WIDTH-1:0] m_den_out,
    output logic                  m_undefined_flag
);

    op_t                   op;
    logic                  busy;
    logic                  start;
    logic                  out_free;
    logic                  load;
    status_t               status;
    logic [DATA_WIDTH-1:0] gcd, num_quot, den_quot;
    logic                  num_neg, den_neg;

    logic                  m_valid_reg;
    logic [DATA_WIDTH-2:0] cd_reg;
    logic [DATA_WIDTH-1:0] num_out_reg, den_out_reg;
    logic                  flag_reg;

    assign s_ready  = aresetn && !busy;
    assign start    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign load     = ((op == OP_FINISH) || (op == OP_FINISH_ERR)) && out_free;

    frgcd_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .status  (status),
        .op      (op),
        .busy    (busy)
    );

    frgcd_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .start    (start),
        .num_in   (s_num_in),
        .den_in   (s_den_in),
        .op       (op),
        .out_free (out_free),
        .status   (status),
        .gcd      (gcd),
        .num_quot (num_quot),
        .den_quot (den_quot),
        .num_neg  (num_neg),
        .den_neg  (den_neg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (op == OP_FINISH_ERR) begin
                cd_reg      <= '0;
                num_out_reg <= '0;
                den_out_reg <= '0;
                flag_reg    <= 1'b1;
            end else begin
                cd_reg      <= gcd[DATA_WIDTH-1] ? {(DATA_WIDTH-1){1'b1}}
                                                 : gcd[DATA_WIDTH-2:0];
                num_out_reg <= num_neg ? (DATA_WIDTH'(0) - num_quot) : num_quot;
                den_out_reg <= den_neg ? (DATA_WIDTH'(0) - den_quot) : den_quot;
                flag_reg    <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_common_divisor = cd_reg;
    assign m_num_out        = num_out_reg;
    assign m_den_out        = den_out_reg;
    assign m_undefined_flag = flag_reg;

endmodule
